>>> rtl/core/bhq_pkg.sv
`timescale 1ns / 1ps

package bhq_pkg;

  localparam int OpWidth       = 2;
  localparam int KeyFieldWidth = 32;
  localparam int SlotWidth     = 10;
  localparam int StatusWidth   = 2;
  localparam int EntriesWidth  = 11;
  localparam int InDataWidth   = 48;
  localparam int OutDataWidth  = 80;

  typedef enum logic [OpWidth-1:0] {
    OP_INSERT,
    OP_POP,
    OP_REMOVE,
    OP_REPLACE
  } op_t;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK,
    STATUS_FULL,
    STATUS_EMPTY,
    STATUS_BEYOND
  } status_t;

  typedef struct packed {
    logic    load_in;
    logic    ins_start;
    logic    pop_start;
    logic    rm_start;
    logic    rp_read;
    logic    pop_load;
    logic    rm_load;
    logic    rp_load;
    logic    rd_parent;
    logic    rd_child;
    logic    move_up;
    logic    move_down;
    logic    place;
    logic    set_status;
    status_t status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic beyond;
    logic count_zero;
    logic last_slot;
    logic idx_zero;
    logic no_child;
    logic up_less;
    logic rp_less;
    logic down_less;
  } stat_t;

endpackage

>>> rtl/core/binary_min_heap_queue_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// s_axis    in   tuser: op; tdata: key, slot
// m_axis    out  tdata: status, removed_key, min_valid, min_key, entries
//
// One operation at a time; each heap level costs a read step and a compare
// step on the two-read-port key store. rst clears the entry count and the
// controller; the store needs no clearing. A result waiting on m_axis does
// not block the next s_axis beat; the block stalls only when a second result
// is ready before the first is taken.

module binary_min_heap_queue_top #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bhq_pkg::InDataWidth-1:0]   s_axis_tdata,  // key, slot, zero fill
  input  logic [bhq_pkg::OpWidth-1:0]       s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bhq_pkg::OutDataWidth-1:0]  m_axis_tdata   // status, removed_key,
                                                           // min_valid, min_key,
                                                           // entries, zero fill
);

  bhq_pkg::cmd_t  cmd;
  bhq_pkg::stat_t stat;

  logic signed [bhq_pkg::KeyFieldWidth-1:0] key_in;
  logic [bhq_pkg::SlotWidth-1:0]            slot_in;
  logic [bhq_pkg::StatusWidth-1:0]          status;
  logic [bhq_pkg::KeyFieldWidth-1:0]        removed_key;
  logic                                     min_valid;
  logic [bhq_pkg::KeyFieldWidth-1:0]        min_key;
  logic [bhq_pkg::EntriesWidth-1:0]         entries;

  assign key_in  = s_axis_tdata[bhq_pkg::KeyFieldWidth-1:0];
  assign slot_in = s_axis_tdata[bhq_pkg::KeyFieldWidth +: bhq_pkg::SlotWidth];

  assign m_axis_tdata = {
    2'b00, entries, min_key, min_valid, removed_key, status
  };

  bhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bhq_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op_in       (s_axis_tuser),
    .key_in      (key_in),
    .slot_in     (slot_in),
    .status      (status),
    .removed_key (removed_key),
    .min_valid   (min_valid),
    .min_key     (min_key),
    .entries     (entries)
  );

endmodule

>>> rtl/core/bhq_ctrl.sv
`timescale 1ns / 1ps

module bhq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bhq_pkg::stat_t stat,
  output bhq_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_LD,
    S_RM_LD,
    S_RP_LD,
    S_UP_RD,
    S_UP_EV,
    S_DN_RD,
    S_DN_EV,
    S_DONE
  } state_t;

  state_t state;
  logic   first;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = bhq_pkg::STATUS_OK;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        case (stat.op)
          bhq_pkg::OP_INSERT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhq_pkg::STATUS_FULL;
            end else begin
              cmd.ins_start = 1'b1;
            end
          end
          bhq_pkg::OP_POP: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhq_pkg::STATUS_EMPTY;
            end else begin
              cmd.pop_start = 1'b1;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhq_pkg::STATUS_EMPTY;
            end else if (stat.beyond) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhq_pkg::STATUS_BEYOND;
            end else if (stat.op == bhq_pkg::OP_REMOVE) begin
              cmd.rm_start = 1'b1;
            end else begin
              cmd.rp_read = 1'b1;
            end
          end
        endcase
      end
      S_POP_LD: begin
        cmd.pop_load = !stat.count_zero;
      end
      S_RM_LD: begin
        cmd.rm_load = 1'b1;
      end
      S_RP_LD: begin
        cmd.rp_load = 1'b1;
      end
      S_UP_RD: begin
        if (stat.idx_zero) begin
          cmd.place = !first;
        end else begin
          cmd.rd_parent = 1'b1;
        end
      end
      S_UP_EV: begin
        if (stat.up_less) begin
          cmd.move_up = 1'b1;
        end else begin
          cmd.place = !first;
        end
      end
      S_DN_RD: begin
        if (stat.no_child) begin
          cmd.place = 1'b1;
        end else begin
          cmd.rd_child = 1'b1;
        end
      end
      S_DN_EV: begin
        if (stat.down_less) begin
          cmd.move_down = 1'b1;
        end else begin
          cmd.place = 1'b1;
        end
      end
      S_DONE: begin
        cmd.out_load = !out_valid || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          first <= 1'b0;
          if (cmd.set_status) begin
            state <= S_DONE;
          end else begin
            case (stat.op)
              bhq_pkg::OP_INSERT: state <= S_UP_RD;
              bhq_pkg::OP_POP:    state <= S_POP_LD;
              bhq_pkg::OP_REMOVE: state <= S_RM_LD;
              default:            state <= S_RP_LD;
            endcase
          end
        end
        S_POP_LD: begin
          state <= stat.count_zero ? S_DONE : S_DN_RD;
        end
        S_RM_LD: begin
          first <= 1'b1;
          state <= stat.last_slot ? S_DONE : S_UP_RD;
        end
        S_RP_LD: begin
          state <= stat.rp_less ? S_UP_RD : S_DN_RD;
        end
        S_UP_RD: begin
          if (stat.idx_zero) begin
            state <= first ? S_DN_RD : S_DONE;
          end else begin
            state <= S_UP_EV;
          end
        end
        S_UP_EV: begin
          if (stat.up_less) begin
            first <= 1'b0;
            state <= S_UP_RD;
          end else begin
            state <= first ? S_DN_RD : S_DONE;
          end
        end
        S_DN_RD: begin
          state <= stat.no_child ? S_DONE : S_DN_EV;
        end
        S_DN_EV: begin
          state <= stat.down_less ? S_DN_RD : S_DONE;
        end
        S_DONE: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/bhq_datapath.sv
`timescale 1ns / 1ps

module bhq_datapath #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  bhq_pkg::cmd_t                              cmd,
  output bhq_pkg::stat_t                             stat,
  input  logic [bhq_pkg::OpWidth-1:0]                op_in,
  input  logic signed [bhq_pkg::KeyFieldWidth-1:0]   key_in,
  input  logic [bhq_pkg::SlotWidth-1:0]              slot_in,
  output logic [bhq_pkg::StatusWidth-1:0]            status,
  output logic [bhq_pkg::KeyFieldWidth-1:0]          removed_key,
  output logic                                       min_valid,
  output logic [bhq_pkg::KeyFieldWidth-1:0]          min_key,
  output logic [bhq_pkg::EntriesWidth-1:0]           entries
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int MW = (CW > bhq_pkg::SlotWidth) ? CW : bhq_pkg::SlotWidth;

  logic signed [KEY_WIDTH-1:0] mem [CAPACITY];

  logic [CW-1:0]               count;
  logic [AW-1:0]               idx;
  logic signed [KEY_WIDTH-1:0] val;
  logic signed [KEY_WIDTH-1:0] root;
  logic signed [KEY_WIDTH-1:0] key_q;
  logic [bhq_pkg::SlotWidth-1:0] slot_q;
  bhq_pkg::op_t                op_q;
  bhq_pkg::status_t            status_q;
  logic signed [KEY_WIDTH-1:0] removed;
  logic signed [KEY_WIDTH-1:0] rd0;
  logic signed [KEY_WIDTH-1:0] rd1;

  logic [AW-1:0]               rd_addr0;
  logic [AW-1:0]               rd_addr1;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic signed [KEY_WIDTH-1:0] wdata;

  logic [AW-1:0]               slot_idx;
  logic [AW-1:0]               parent;
  logic [AW-1:0]               last_idx;
  logic [XW-1:0]               left;
  logic [XW-1:0]               right;
  logic [XW-1:0]               count_x;
  logic                        right_ok;
  logic                        pick_r;
  logic signed [KEY_WIDTH-1:0] child_val;
  logic [AW-1:0]               child_idx;
  logic signed [bhq_pkg::KeyFieldWidth-1:0] root_ext;
  logic signed [bhq_pkg::KeyFieldWidth-1:0] removed_ext;

  assign slot_idx  = AW'(slot_q);
  assign parent    = AW'((idx - 1'b1) >> 1);
  assign last_idx  = AW'(count - 1'b1);
  assign count_x   = XW'(count);
  assign left      = (XW'(idx) << 1) + XW'(1);
  assign right     = left + XW'(1);
  assign right_ok  = right < count_x;
  assign pick_r    = right_ok && (rd1 < rd0);
  assign child_val = pick_r ? rd1 : rd0;
  assign child_idx = pick_r ? AW'(right) : AW'(left);

  assign stat.op         = op_q;
  assign stat.full       = count >= CW'(CAPACITY);
  assign stat.empty      = count == '0;
  assign stat.beyond     = MW'(slot_q) >= MW'(count);
  assign stat.count_zero = count == '0;
  assign stat.last_slot  = MW'(slot_q) == MW'(count);
  assign stat.idx_zero   = idx == '0;
  assign stat.no_child   = left >= count_x;
  assign stat.up_less    = val < rd0;
  assign stat.rp_less    = key_q < rd0;
  assign stat.down_less  = child_val < val;

  always_comb begin
    rd_addr0 = idx;
    rd_addr1 = idx;
    if (cmd.rm_start || cmd.rp_read) begin
      rd_addr0 = slot_idx;
    end else if (cmd.rd_parent) begin
      rd_addr0 = parent;
    end else if (cmd.rd_child) begin
      rd_addr0 = AW'(left);
      rd_addr1 = right_ok ? AW'(right) : AW'(left);
    end
    if (cmd.pop_start || cmd.rm_start) begin
      rd_addr1 = last_idx;
    end
  end

  always_comb begin
    we    = cmd.move_up || cmd.move_down || cmd.place;
    waddr = idx;
    wdata = val;
    if (cmd.move_up) begin
      wdata = rd0;
    end else if (cmd.move_down) begin
      wdata = child_val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[rd_addr0];
    rd1 <= mem[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_start) begin
      count <= count + 1'b1;
    end else if (cmd.pop_start || cmd.rm_start) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
    if (cmd.load_in) begin
      op_q     <= bhq_pkg::op_t'(op_in);
      key_q    <= KEY_WIDTH'(key_in);
      slot_q   <= slot_in;
      status_q <= bhq_pkg::STATUS_OK;
      removed  <= '0;
    end
    if (cmd.set_status) begin
      status_q <= cmd.status;
    end
    if (cmd.ins_start) begin
      idx <= AW'(count);
      val <= key_q;
    end
    if (cmd.pop_start) begin
      removed <= root;
    end
    if (cmd.pop_load) begin
      val <= rd1;
      idx <= '0;
    end
    if (cmd.rm_load) begin
      removed <= rd0;
      val     <= rd1;
      idx     <= slot_idx;
    end
    if (cmd.rp_load) begin
      val <= key_q;
      idx <= slot_idx;
    end
    if (cmd.move_up) begin
      idx <= parent;
    end
    if (cmd.move_down) begin
      idx <= child_idx;
    end
  end

  assign root_ext    = bhq_pkg::KeyFieldWidth'(root);
  assign removed_ext = bhq_pkg::KeyFieldWidth'(removed);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= status_q;
      removed_key <= removed_ext;
      min_valid   <= count != '0;
      min_key     <= (count != '0) ? root_ext : '0;
      entries     <= bhq_pkg::EntriesWidth'(count);
    end
  end

endmodule

>>> test/bhq_checker.sv
`timescale 1ns / 1ps

module bhq_checker
  import bhq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  input  logic [OpWidth-1:0]      s_axis_tuser,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [OutDataWidth-1:0] m_axis_tdata,
  output int                      errors,
  output int                      pending
);

  typedef struct {
    status_t            status;
    logic signed [31:0] removed_key;
    logic               min_valid;
    logic signed [31:0] min_key;
    logic [10:0]        entries;
  } heap_outcome_t;

  logic signed [31:0] heap_keys [CAPACITY];
  int                 heap_size;
  heap_outcome_t      awaited_outcomes [$];

  initial begin
    errors    = 0;
    pending   = 0;
    heap_size = 0;
  end

  function automatic void swap_keys(int a, int b);
    logic signed [31:0] t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void bubble_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_keys[i] < heap_keys[p]) begin
        swap_keys(i, p);
        i = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void sink_down(int i);
    int l;
    int c;
    while (2 * i + 1 < heap_size) begin
      l = 2 * i + 1;
      c = l;
      if (l + 1 < heap_size && heap_keys[l + 1] < heap_keys[l]) c = l + 1;
      if (heap_keys[c] < heap_keys[i]) begin
        swap_keys(i, c);
        i = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic heap_outcome_t apply_heap_op(op_t op, logic signed [31:0] key,
                                                  int slot);
    heap_outcome_t      r;
    logic signed [31:0] prior;
    r.status      = STATUS_OK;
    r.removed_key = '0;
    case (op)
      OP_INSERT: begin
        if (heap_size >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          heap_keys[heap_size] = key;
          heap_size++;
          bubble_up(heap_size - 1);
        end
      end
      OP_POP: begin
        if (heap_size == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.removed_key = heap_keys[0];
          heap_size--;
          if (heap_size > 0) begin
            heap_keys[0] = heap_keys[heap_size];
            sink_down(0);
          end
        end
      end
      default: begin
        if (heap_size == 0) begin
          r.status = STATUS_EMPTY;
        end else if (slot >= heap_size) begin
          r.status = STATUS_BEYOND;
        end else if (op == OP_REMOVE) begin
          r.removed_key = heap_keys[slot];
          heap_size--;
          if (slot != heap_size) begin
            heap_keys[slot] = heap_keys[heap_size];
            if (slot > 0 && heap_keys[slot] < heap_keys[(slot - 1) / 2]) bubble_up(slot);
            else sink_down(slot);
          end
        end else begin
          prior           = heap_keys[slot];
          heap_keys[slot] = key;
          if (key < prior) bubble_up(slot);
          else sink_down(slot);
        end
      end
    endcase
    r.min_valid = (heap_size > 0);
    r.min_key   = (heap_size > 0) ? heap_keys[0] : '0;
    r.entries   = 11'(heap_size);
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    heap_outcome_t want;
    if (rst) begin
      heap_size = 0;
      awaited_outcomes.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        awaited_outcomes.push_back(apply_heap_op(op_t'(s_axis_tuser),
                                                 $signed(s_axis_tdata[31:0]),
                                                 int'(s_axis_tdata[41:32])));
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result beat with no outstanding operation");
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("status", want.status, m_axis_tdata[1:0]);
          check_field("removed_key", want.removed_key, $signed(m_axis_tdata[33:2]));
          check_field("min_valid", want.min_valid, m_axis_tdata[34]);
          check_field("min_key", want.min_key, $signed(m_axis_tdata[66:35]));
          check_field("entries", want.entries, m_axis_tdata[77:67]);
        end
      end
    end
    pending = awaited_outcomes.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import bhq_pkg::*;

  localparam int CAPACITY   = 1024;
  localparam int StallLimit = 4000;

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata  = '0;
  logic [OpWidth-1:0]      s_axis_tuser  = OP_INSERT;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;

  int errors;
  int pending;
  int held         = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  binary_min_heap_queue_top #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(32)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bhq_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (errors),
    .pending      (pending)
  );

  function automatic logic [31:0] rand_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    if (r < 5) return 32'($urandom_range(0, 16)) - 32'd8;
    return $urandom;
  endfunction

  function automatic logic [SlotWidth-1:0] pick_slot();
    if (held == 0 || $urandom_range(0, 6) == 0) return SlotWidth'($urandom_range(0, 1023));
    return SlotWidth'($urandom_range(0, held - 1));
  endfunction

  task automatic issue(op_t op, logic [31:0] key, logic [SlotWidth-1:0] slot);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataWidth - KeyFieldWidth - SlotWidth){1'b0}}, slot, key};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    case (op)
      OP_INSERT: if (held < CAPACITY) held++;
      OP_POP:    if (held > 0) held--;
      OP_REMOVE: if (held > 0 && int'(slot) < held) held--;
      default:   ;
    endcase
  endtask

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("binary_min_heap_queue_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : sink_side
    bit backed_up;
    backed_up = 1'b0;
    @(negedge rst);
    forever begin
      if (!backed_up && results_seen >= 150) begin
        backed_up = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : source_side
    int   r;
    op_t  op;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    issue(OP_POP, rand_key(), '0);
    issue(OP_REMOVE, rand_key(), '0);
    issue(OP_REPLACE, rand_key(), '0);
    issue(OP_INSERT, 32'd5, '0);
    issue(OP_INSERT, 32'h7fff_ffff, 10'h3ff);
    issue(OP_INSERT, 32'h8000_0000, '0);
    issue(OP_INSERT, 32'd0, '0);
    issue(OP_INSERT, 32'hffff_ffff, '0);
    issue(OP_INSERT, 32'd5, '0);
    issue(OP_INSERT, 32'd5, '0);
    issue(OP_REMOVE, rand_key(), 10'd7);
    issue(OP_REPLACE, rand_key(), 10'h3ff);
    issue(OP_REPLACE, -32'sd100, 10'd6);
    issue(OP_REPLACE, 32'h7fff_fffe, 10'd0);
    issue(OP_REPLACE, 32'd5, 10'd3);
    issue(OP_REMOVE, rand_key(), 10'd6);
    issue(OP_REMOVE, rand_key(), 10'd1);
    issue(OP_REMOVE, rand_key(), 10'd0);
    repeat (5) issue(OP_POP, rand_key(), pick_slot());

    repeat (430) begin
      r  = $urandom_range(0, 99);
      op = (r < 45) ? OP_INSERT : (r < 64) ? OP_POP : (r < 82) ? OP_REMOVE : OP_REPLACE;
      if (held < 2 && $urandom_range(0, 9) < 7) op = OP_INSERT;
      issue(op, rand_key(), pick_slot());
    end

    calm = 1'b1;
    issue(OP_INSERT, rand_key(), pick_slot());
    issue(OP_INSERT, 32'h8000_0000, pick_slot());
    issue(OP_REPLACE, rand_key(), 10'(CAPACITY - 1));
    issue(OP_REMOVE, rand_key(), 10'(CAPACITY - 1));
    while (held > 0) begin
      r  = $urandom_range(0, 9);
      op = (r < 4) ? OP_POP : (r < 7) ? OP_REMOVE : (r < 9) ? OP_REPLACE : OP_INSERT;
      issue(op, rand_key(), pick_slot());
    end
    issue(OP_POP, rand_key(), pick_slot());

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("binary_min_heap_queue_top regression: pass");
    end else begin
      $display("binary_min_heap_queue_top regression: fail");
    end
    $finish;
  end

endmodule
